// ===== rtl/core/slsfr_pkg.sv =====
package slsfr_pkg;

  localparam int MAX_PAYLOAD = 16;
  localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int TELEM_LEN   = 7;

  localparam logic [7:0] SYNC_FIRST      = 8'hAA;
  localparam logic [7:0] SYNC_SECOND     = 8'h55;
  localparam logic [7:0] DEVICE_RESET    = 8'h01;
  localparam logic [7:0] CMD_STATUS      = 8'h80;
  localparam logic [7:0] CMD_ERROR       = 8'h81;
  localparam logic [7:0] CMD_BREW_DONE   = 8'h82;
  localparam logic [7:0] CMD_TELEMETRY   = 8'h83;

  typedef enum logic [2:0] {
    ST_HUNT1 = 3'd0,
    ST_HUNT2 = 3'd1,
    ST_DEV   = 3'd2,
    ST_CMD   = 3'd3,
    ST_LEN   = 3'd4,
    ST_DATA  = 3'd5,
    ST_SUM   = 3'd6
  } parser_state_t;

  typedef enum logic [2:0] {
    KIND_STATUS    = 3'd0,
    KIND_BREW_DONE = 3'd1,
    KIND_ERROR     = 3'd2,
    KIND_TELEMETRY = 3'd3,
    KIND_OTHER     = 3'd4
  } frame_kind_t;

  typedef struct packed {
    logic [7:0]                 command;
    logic [LEN_W-1:0]           length;
    logic [TELEM_LEN-1:0][7:0]  payload;
  } frame_info_t;

  typedef struct packed {
    frame_kind_t        kind;
    logic [7:0]         command;
    logic [LEN_W-1:0]   length;
    logic [7:0]         report;
    logic [7:0]         stage;
    logic signed [15:0] weight;
    logic signed [15:0] water;
    logic [7:0]         heater;
    logic [7:0]         target;
  } result_t;

endpackage

// ===== rtl/core/slsfr_classify.sv =====
module slsfr_classify (
  input  slsfr_pkg::frame_info_t info,
  output slsfr_pkg::result_t     res
);

  always_comb begin
    res         = '0;
    res.kind    = slsfr_pkg::KIND_OTHER;
    res.command = info.command;
    res.length  = info.length;
    // Detail fields are only filled when the length covers the bytes read,
    // so every payload byte used here was written by the current frame.
    if (info.command == slsfr_pkg::CMD_STATUS && info.length != '0) begin
      res.kind   = slsfr_pkg::KIND_STATUS;
      res.report = info.payload[0];
    end else if (info.command == slsfr_pkg::CMD_BREW_DONE) begin
      res.kind = slsfr_pkg::KIND_BREW_DONE;
    end else if (info.command == slsfr_pkg::CMD_ERROR && info.length != '0) begin
      res.kind   = slsfr_pkg::KIND_ERROR;
      res.report = info.payload[0];
    end else if (info.command == slsfr_pkg::CMD_TELEMETRY &&
                 info.length >= slsfr_pkg::LEN_W'(slsfr_pkg::TELEM_LEN)) begin
      res.kind   = slsfr_pkg::KIND_TELEMETRY;
      res.stage  = info.payload[0];
      res.weight = {info.payload[1], info.payload[2]};
      res.water  = {info.payload[3], info.payload[4]};
      res.heater = info.payload[5];
      res.target = info.payload[6];
    end
  end

endmodule

// ===== rtl/core/sync_length_sum_frame_receiver_core.sv =====
// Frame receiver for a byte stream: sync pair 0xAA 0x55, device, command,
// length, up to 16 payload bytes and an additive checksum byte.
// Input channel rx_valid/rx_ready/rx_byte carries one received word per
// handshake. Output channel out_valid/out_ready carries one decoded frame
// (kind, command, length and the unpacked status, error or telemetry fields).
// cfg_valid/cfg_ready/cfg_data writes the expected device byte; cfg_ready
// is always high.
// Throughput is one word per cycle unless a checksum word waits for space.
// The parser steps through its states as words arrive, and the checksum and
// device compare plus command decode feed the output register directly.
// Reset returns the parser to the sync hunt, empties the output register
// and sets the expected device to 0x01.
// When the receiver stalls, the output register holds the result. Words
// keep being accepted while that result waits, except a checksum word,
// which is held off until the output register is free.
module sync_length_sum_frame_receiver_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           rx_valid,
  output logic                           rx_ready,
  input  logic [7:0]                     rx_byte,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [7:0]                     cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     frame_kind,
  output logic [7:0]                     command_code,
  output logic [slsfr_pkg::LEN_W-1:0]    payload_length,
  output logic [7:0]                     report_code,
  output logic [7:0]                     stage,
  output logic signed [15:0]             weight_tenths,
  output logic signed [15:0]             water_tenths,
  output logic [7:0]                     heater_on,
  output logic [7:0]                     target_temp
);

  slsfr_pkg::parser_state_t                     state, state_next;
  logic [7:0]                                   expected_device;
  logic [7:0]                                   device_byte;
  logic [7:0]                                   command_byte;
  logic [slsfr_pkg::LEN_W-1:0]                  frame_length;
  logic [slsfr_pkg::LEN_W-1:0]                  byte_index;
  logic [slsfr_pkg::LEN_W-1:0]                  byte_index_next;
  logic [7:0]                                   running_sum;
  logic [7:0]                                   running_sum_next;
  logic [slsfr_pkg::TELEM_LEN-1:0][7:0]         payload;
  logic                                         rx_fire;
  logic                                         emit;
  slsfr_pkg::frame_info_t                       info;
  slsfr_pkg::result_t                           res;
  slsfr_pkg::result_t                           result;

  assign rx_fire          = rx_valid && rx_ready;
  assign cfg_ready        = 1'b1;
  assign byte_index_next  = byte_index + 1'b1;
  assign running_sum_next = running_sum + rx_byte;

  always_comb begin
    state_next = state;
    if (rx_fire) begin
      case (state)
        slsfr_pkg::ST_HUNT1: begin
          if (rx_byte == slsfr_pkg::SYNC_FIRST) state_next = slsfr_pkg::ST_HUNT2;
        end
        slsfr_pkg::ST_HUNT2: begin
          state_next = (rx_byte == slsfr_pkg::SYNC_SECOND) ? slsfr_pkg::ST_DEV
                                                           : slsfr_pkg::ST_HUNT1;
        end
        slsfr_pkg::ST_DEV: state_next = slsfr_pkg::ST_CMD;
        slsfr_pkg::ST_CMD: state_next = slsfr_pkg::ST_LEN;
        slsfr_pkg::ST_LEN: begin
          if (rx_byte > 8'(slsfr_pkg::MAX_PAYLOAD)) state_next = slsfr_pkg::ST_HUNT1;
          else if (rx_byte == 8'h00)                state_next = slsfr_pkg::ST_SUM;
          else                                      state_next = slsfr_pkg::ST_DATA;
        end
        slsfr_pkg::ST_DATA: begin
          if (byte_index_next >= frame_length) state_next = slsfr_pkg::ST_SUM;
        end
        default: state_next = slsfr_pkg::ST_HUNT1;
      endcase
    end
  end

  // Only the checksum word can produce a result, so only it waits for space.
  always_comb begin
    rx_ready = (state != slsfr_pkg::ST_SUM) || !out_valid || out_ready;
    emit     = rx_fire && (state == slsfr_pkg::ST_SUM) &&
               (rx_byte == running_sum) && (device_byte == expected_device);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= slsfr_pkg::ST_HUNT1;
      expected_device <= slsfr_pkg::DEVICE_RESET;
      device_byte     <= '0;
      command_byte    <= '0;
      frame_length    <= '0;
      byte_index      <= '0;
      running_sum     <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) expected_device <= cfg_data;
      if (rx_fire) begin
        case (state)
          slsfr_pkg::ST_DEV: begin
            device_byte <= rx_byte;
            running_sum <= rx_byte;
          end
          slsfr_pkg::ST_CMD: begin
            command_byte <= rx_byte;
            running_sum  <= running_sum_next;
          end
          slsfr_pkg::ST_LEN: begin
            frame_length <= rx_byte[slsfr_pkg::LEN_W-1:0];
            byte_index   <= '0;
            running_sum  <= running_sum_next;
          end
          slsfr_pkg::ST_DATA: begin
            byte_index  <= byte_index_next;
            running_sum <= running_sum_next;
          end
          default: ;
        endcase
      end
    end
  end

  // Only the leading payload bytes are ever decoded; later ones feed the sum only.
  always_ff @(posedge clk) begin
    for (int i = 0; i < slsfr_pkg::TELEM_LEN; i++) begin
      if (rx_fire && state == slsfr_pkg::ST_DATA &&
          byte_index == slsfr_pkg::LEN_W'(i)) begin
        payload[i] <= rx_byte;
      end
    end
  end

  assign info.command = command_byte;
  assign info.length  = frame_length;
  assign info.payload = payload;

  slsfr_classify u_classify (
    .info (info),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) result <= res;
  end

  assign frame_kind     = result.kind;
  assign command_code   = result.command;
  assign payload_length = result.length;
  assign report_code    = result.report;
  assign stage          = result.stage;
  assign weight_tenths  = result.weight;
  assign water_tenths   = result.water;
  assign heater_on      = result.heater;
  assign target_temp    = result.target;

endmodule

// ===== rtl/core/slsfr_checker.sv =====
module slsfr_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [2:0]                     frame_kind,
  input logic [7:0]                     command_code,
  input logic [slsfr_pkg::LEN_W-1:0]    payload_length,
  input logic [7:0]                     report_code,
  input logic [7:0]                     stage,
  input logic signed [15:0]             weight_tenths,
  input logic signed [15:0]             water_tenths,
  input logic [7:0]                     heater_on,
  input logic [7:0]                     target_temp
);

  // The output register is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  // A stalled result keeps its kind, command and length.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(command_code) &&
      $stable(payload_length) && $stable(frame_kind))
    else $error("stalled result changed");

  a_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> payload_length <= slsfr_pkg::LEN_W'(slsfr_pkg::MAX_PAYLOAD))
    else $error("result length above payload limit");

  // Telemetry needs the full field set, and only telemetry carries its fields.
  a_telem: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_kind == 3'(slsfr_pkg::KIND_TELEMETRY) |->
      payload_length >= slsfr_pkg::LEN_W'(slsfr_pkg::TELEM_LEN) &&
      command_code == slsfr_pkg::CMD_TELEMETRY && report_code == 8'h00)
    else $error("telemetry result inconsistent");

  a_other: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_kind != 3'(slsfr_pkg::KIND_TELEMETRY) |->
      weight_tenths == 16'sd0 && water_tenths == 16'sd0 && stage == 8'h00 &&
      heater_on == 8'h00 && target_temp == 8'h00)
    else $error("telemetry fields set on another kind");

endmodule

bind sync_length_sum_frame_receiver_core slsfr_checker u_slsfr_checker (.*);
